FILE: hw/rtl/bpm_pkg.sv
package bpm_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned PIN_W      = 12;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_ACTIVE   = 2'd0,
    MODE_IDLE     = 2'd1,
    MODE_SLEEP    = 2'd2,
    MODE_SHUTDOWN = 2'd3
  } mode_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ACTIVITY = 3'd1,
    FUNC_BATTERY  = 3'd2,
    FUNC_SLEEP    = 3'd3,
    FUNC_WAKE     = 3'd4,
    FUNC_SHUTDOWN = 3'd5
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_LOW_THRESH   = 2'd1,
    REG_CRIT_THRESH  = 2'd2
  } reg_idx_t;

  localparam logic [MV_W-1:0]   CURVE_LOW_MV  = 13'd3200;
  localparam logic [MV_W-1:0]   CURVE_HIGH_MV = 13'd4200;
  localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;

  localparam logic [TICK_W-1:0] RST_IDLE_TIMEOUT = 32'd30000;
  localparam logic [MV_W-1:0]   RST_LOW_THRESH   = 13'd3400;
  localparam logic [MV_W-1:0]   RST_CRIT_THRESH  = 13'd3200;

  typedef struct packed {
    mode_t             mode;
    logic [MV_W-1:0]   battery_mv;
    logic [PCT_W-1:0]  charge_percent;
    logic              battery_low;
    logic              battery_critical;
    logic              sleep_request;
    logic              low_event;
  } status_t;

endpackage

FILE: hw/rtl/battery_power_mode_manager.sv
// An event word accepted at the input is captured in the input register, then moves into the
// result register, which drives its status word; while the output is stalled it waits.
// Throughput: one event per cycle while the output is not stalled.
// Reset (rst, synchronous): mode active, counters, battery values and flags cleared,
// configuration registers back to 30000 ticks, 3400 mV and 3200 mV.
module battery_power_mode_manager (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bpm_pkg::FUNC_W-1:0]     func,
  input  logic [bpm_pkg::PIN_W-1:0]      pin_mv,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     mode,
  output logic [bpm_pkg::MV_W-1:0]       battery_mv,
  output logic [bpm_pkg::PCT_W-1:0]      charge_percent,
  output logic                           battery_low,
  output logic                           battery_critical,
  output logic                           sleep_request,
  output logic                           low_event
);
  import bpm_pkg::*;

  logic              s1_valid;
  logic [FUNC_W-1:0] s1_func;
  logic [PIN_W-1:0]  s1_pin;
  logic              advance;
  status_t           next_status;
  status_t           out_status;

  // stage 1 moves into the result register when that register is free or drains
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  bpm_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .func      (s1_func),
    .pin_mv    (s1_pin),
    .status    (next_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_func <= func;
      s1_pin  <= pin_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_status <= next_status;
    end
  end

  assign mode             = out_status.mode;
  assign battery_mv       = out_status.battery_mv;
  assign charge_percent   = out_status.charge_percent;
  assign battery_low      = out_status.battery_low;
  assign battery_critical = out_status.battery_critical;
  assign sleep_request    = out_status.sleep_request;
  assign low_event        = out_status.low_event;

endmodule

FILE: hw/rtl/bpm_percent.sv
module bpm_percent (
  input  logic [bpm_pkg::MV_W-1:0]  mv,
  output logic [bpm_pkg::PCT_W-1:0] percent
);
  import bpm_pkg::*;

  // (mv - 3200) / 10 as a reciprocal multiply: x * 205 >> 11 is exact for x < 1029
  localparam int unsigned DIFF_W      = 10;
  localparam int unsigned RECIP_W     = 8;
  localparam int unsigned PROD_W      = DIFF_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 11;
  localparam logic [RECIP_W-1:0] RECIP = 8'd205;

  logic [MV_W-1:0]   diff;
  logic [PROD_W-1:0] prod;

  assign diff = mv - CURVE_LOW_MV;
  assign prod = PROD_W'(diff[DIFF_W-1:0]) * PROD_W'(RECIP);

  always_comb begin
    if (mv <= CURVE_LOW_MV) begin
      percent = '0;
    end else if (mv >= CURVE_HIGH_MV) begin
      percent = PCT_FULL;
    end else begin
      percent = prod[RECIP_SHIFT +: PCT_W];
    end
  end

endmodule

FILE: hw/rtl/bpm_state.sv
module bpm_state (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           step,
  input  logic [bpm_pkg::FUNC_W-1:0]     func,
  input  logic [bpm_pkg::PIN_W-1:0]      pin_mv,
  output bpm_pkg::status_t               status
);
  import bpm_pkg::*;

  logic [TICK_W-1:0] idle_timeout;
  logic [MV_W-1:0]   low_thresh;
  logic [MV_W-1:0]   crit_thresh;

  mode_t             mode, mode_next;
  logic [TICK_W-1:0] idle_count, idle_count_next;
  logic [MV_W-1:0]   last_mv, last_mv_next;
  logic [PCT_W-1:0]  last_pct, last_pct_next;
  logic              low_flag, low_flag_next;
  logic              crit_flag, crit_flag_next;
  logic              sleep_req, low_ev;

  logic [MV_W-1:0]   sample_mv;
  logic [PCT_W-1:0]  sample_pct;
  logic              cnt_inc;
  logic [TICK_W-1:0] cnt_plus;
  logic              below_low, below_crit;

  assign sample_mv = {pin_mv, 1'b0};

  bpm_percent u_percent (
    .mv      (sample_mv),
    .percent (sample_pct)
  );

  assign cnt_inc    = (idle_count != '1);
  assign cnt_plus   = cnt_inc ? idle_count + 1'b1 : idle_count;
  assign below_low  = (sample_mv < low_thresh);
  assign below_crit = (sample_mv < crit_thresh);

  always_comb begin
    mode_next       = mode;
    idle_count_next = idle_count;
    last_mv_next    = last_mv;
    last_pct_next   = last_pct;
    low_flag_next   = low_flag;
    crit_flag_next  = crit_flag;
    sleep_req       = 1'b0;
    low_ev          = 1'b0;
    if (mode != MODE_SHUTDOWN) begin
      unique case (func)
        FUNC_TICK: begin
          idle_count_next = cnt_plus;
          sleep_req = cnt_inc && (cnt_plus == idle_timeout) && (mode == MODE_ACTIVE);
          if ((cnt_plus > idle_timeout) && (mode == MODE_ACTIVE)) begin
            mode_next = MODE_IDLE;
          end
        end
        FUNC_ACTIVITY: begin
          idle_count_next = '0;
          if (mode == MODE_IDLE || mode == MODE_SLEEP) begin
            mode_next = MODE_ACTIVE;
          end
        end
        FUNC_BATTERY: begin
          last_mv_next   = sample_mv;
          last_pct_next  = sample_pct;
          // flags follow the level; the event fires only on the set edge
          low_flag_next  = below_low;
          low_ev         = below_low && !low_flag;
          crit_flag_next = below_crit;
          if (below_crit && !crit_flag) begin
            mode_next = MODE_SHUTDOWN;
          end
        end
        FUNC_SLEEP: begin
          mode_next = MODE_SLEEP;
        end
        FUNC_WAKE: begin
          mode_next       = MODE_ACTIVE;
          idle_count_next = '0;
        end
        FUNC_SHUTDOWN: begin
          mode_next = MODE_SHUTDOWN;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.mode             = mode_next;
    status.battery_mv       = last_mv_next;
    status.charge_percent   = last_pct_next;
    status.battery_low      = low_flag_next;
    status.battery_critical = crit_flag_next;
    status.sleep_request    = sleep_req;
    status.low_event        = low_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= RST_IDLE_TIMEOUT;
      low_thresh   <= RST_LOW_THRESH;
      crit_thresh  <= RST_CRIT_THRESH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        REG_LOW_THRESH:   low_thresh   <= cfg_data[MV_W-1:0];
        REG_CRIT_THRESH:  crit_thresh  <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ACTIVE;
      idle_count <= '0;
      last_mv    <= '0;
      last_pct   <= '0;
      low_flag   <= 1'b0;
      crit_flag  <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      idle_count <= idle_count_next;
      last_mv    <= last_mv_next;
      last_pct   <= last_pct_next;
      low_flag   <= low_flag_next;
      crit_flag  <= crit_flag_next;
    end
  end

endmodule

FILE: hw/rtl/bpm_checker.sv
module bpm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                mode,
  input logic [bpm_pkg::PCT_W-1:0] charge_percent,
  input logic                      battery_low,
  input logic                      battery_critical,
  input logic                      sleep_request,
  input logic                      low_event
);
  import bpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // a sleep request only comes out of a tick in active mode, which stays active
  a_sleep_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && sleep_request |-> mode == MODE_ACTIVE)
    else $error("sleep request outside active mode");

  a_low_event_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && low_event |-> battery_low)
    else $error("low event without low flag");

  // critical is only ever set together with shutdown, which then sticks
  a_crit_shutdown: assert property (@(posedge clk) disable iff (rst)
    out_valid && battery_critical |-> mode == MODE_SHUTDOWN)
    else $error("critical flag outside shutdown");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> charge_percent <= PCT_FULL)
    else $error("charge percent above full");

endmodule

bind battery_power_mode_manager bpm_checker u_bpm_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bpm_pkg::*;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]    FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0]    FUNC_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  localparam int unsigned MV_PER_PCT = (CURVE_HIGH_MV - CURVE_LOW_MV) / PCT_FULL;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned REPORT_MAX = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func;
  logic [PIN_W-1:0]      pin_mv;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            mode;
  logic [MV_W-1:0]       battery_mv;
  logic [PCT_W-1:0]      charge_percent;
  logic                  battery_low;
  logic                  battery_critical;
  logic                  sleep_request;
  logic                  low_event;

  battery_power_mode_manager i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .pin_mv           (pin_mv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mode             (mode),
    .battery_mv       (battery_mv),
    .charge_percent   (charge_percent),
    .battery_low      (battery_low),
    .battery_critical (battery_critical),
    .sleep_request    (sleep_request),
    .low_event        (low_event)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirrored block state and registers
  mode_t             st_mode;
  logic [TICK_W-1:0] st_count;
  logic [MV_W-1:0]   st_mv;
  logic [PCT_W-1:0]  st_pct;
  logic              st_low;
  logic              st_crit;
  logic [TICK_W-1:0] cfg_timeout;
  logic [MV_W-1:0]   cfg_low;
  logic [MV_W-1:0]   cfg_crit;

  status_t status_q[$];
  bit      no_gaps;
  int      n_bad;
  int      n_words;
  int      n_results;
  int      n_sleep_req;
  int      n_low_ev;
  int      n_settings;
  int      stuck;

  function automatic status_t predict_status(input logic [FUNC_W-1:0] f,
                                             input logic [PIN_W-1:0] p);
    status_t r;
    logic    req;
    logic    ev;
    req = 1'b0;
    ev  = 1'b0;
    if (st_mode != MODE_SHUTDOWN) begin
      case (f)
        FUNC_TICK: begin
          if (st_count != '1) begin
            st_count = st_count + 1'b1;
            if (st_count == cfg_timeout && st_mode == MODE_ACTIVE) req = 1'b1;
          end
          if (st_count > cfg_timeout && st_mode == MODE_ACTIVE) st_mode = MODE_IDLE;
        end
        FUNC_ACTIVITY: begin
          st_count = '0;
          if (st_mode == MODE_IDLE || st_mode == MODE_SLEEP) st_mode = MODE_ACTIVE;
        end
        FUNC_BATTERY: begin
          st_mv = {p, 1'b0};
          if (st_mv <= CURVE_LOW_MV) st_pct = '0;
          else if (st_mv >= CURVE_HIGH_MV) st_pct = PCT_FULL;
          else st_pct = PCT_W'((st_mv - CURVE_LOW_MV) / MV_PER_PCT);
          if (st_mv >= cfg_low) st_low = 1'b0;
          if (st_mv >= cfg_crit) st_crit = 1'b0;
          if (st_mv < cfg_low && !st_low) begin
            st_low = 1'b1;
            ev = 1'b1;
          end
          if (st_mv < cfg_crit && !st_crit) begin
            st_crit = 1'b1;
            st_mode = MODE_SHUTDOWN;
          end
        end
        FUNC_SLEEP: st_mode = MODE_SLEEP;
        FUNC_WAKE: begin
          st_mode = MODE_ACTIVE;
          st_count = '0;
        end
        FUNC_SHUTDOWN: st_mode = MODE_SHUTDOWN;
        default: ;
      endcase
    end
    r.mode             = st_mode;
    r.battery_mv       = st_mv;
    r.charge_percent   = st_pct;
    r.battery_low      = st_low;
    r.battery_critical = st_crit;
    r.sleep_request    = req;
    r.low_event        = ev;
    return r;
  endfunction

  task automatic send_event(input logic [FUNC_W-1:0] f, input logic [PIN_W-1:0] p);
    status_t s;
    while (!no_gaps && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    pin_mv   <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s = predict_status(f, p);
    status_q.push_back(s);
    n_words++;
    n_sleep_req += s.sleep_request;
    n_low_ev    += s.low_event;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all three registers plus the unused index, which must change nothing
  task automatic load_config(input logic [TICK_W-1:0] t, input logic [MV_W-1:0] lo,
                             input logic [MV_W-1:0] cr);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_index <= REG_IDLE_TIMEOUT;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= REG_LOW_THRESH;
    cfg_data  <= {19'($urandom), lo};
    @(posedge clk);
    cfg_index <= REG_CRIT_THRESH;
    cfg_data  <= {19'($urandom), cr};
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_timeout = t;
    cfg_low     = lo;
    cfg_crit    = cr;
    n_settings++;
  endtask

  // biased toward the curve ends and the low threshold
  function automatic logic [PIN_W-1:0] pick_pin();
    int c;
    int lo;
    int hi;
    c  = cfg_low / 2;
    lo = (c < 2) ? 0 : c - 2;
    hi = (c + 2 > 4095) ? 4095 : c + 2;
    case ($urandom_range(3))
      0: return PIN_W'($urandom_range(4095));
      1: return PIN_W'($urandom_range(2110, 1590));
      2: return PIN_W'($urandom_range(hi, lo));
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return PIN_W'(1600);
          default: return PIN_W'(2100);
        endcase
      end
    endcase
  endfunction

  task automatic test_power_on_defaults();
    send_event(FUNC_TICK, '1);
    send_event(FUNC_ACTIVITY, '0);
    send_event(FUNC_BATTERY, 12'd2100);
    send_event(FUNC_BATTERY, 12'd4095);
    send_event(FUNC_BATTERY, 12'd1700);
    send_event(FUNC_BATTERY, 12'd1699);
    send_event(FUNC_BATTERY, 12'd1698);
    send_event(FUNC_BATTERY, 12'd1601);
    send_event(FUNC_BATTERY, 12'd1600);
    send_event(FUNC_SPARE_6, 12'hA5A);
    send_event(FUNC_SPARE_7, 12'h5A5);
    send_event(FUNC_SLEEP, '0);
    send_event(FUNC_WAKE, '0);
  endtask

  task automatic test_idle_timeout();
    load_config(32'd3, 13'd3400, 13'd0);
    send_event(FUNC_ACTIVITY, '0);
    repeat (4) send_event(FUNC_TICK, '0);
    send_event(FUNC_ACTIVITY, '0);
    send_event(FUNC_SLEEP, '0);
    repeat (4) send_event(FUNC_TICK, '0);
    send_event(FUNC_BATTERY, '0);
    send_event(FUNC_BATTERY, '1);
    send_event(FUNC_BATTERY, '0);
  endtask

  task automatic test_timeout_extremes();
    load_config(32'd0, 13'd0, 13'd0);
    send_event(FUNC_WAKE, '0);
    send_event(FUNC_TICK, '0);
    load_config(32'd1, 13'h1FFF, 13'd0);
    send_event(FUNC_WAKE, '0);
    send_event(FUNC_TICK, '0);
    send_event(FUNC_TICK, '0);
    load_config('1, 13'd3400, 13'd0);
    send_event(FUNC_WAKE, '0);
    repeat (3) send_event(FUNC_TICK, '0);
  endtask

  // critical level is held at zero here, so shutdown never locks the block
  task automatic test_random_traffic();
    logic [TICK_W-1:0] t;
    logic [MV_W-1:0]   lo;
    int                r;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        3:       t = '0;
        5:       t = '1;
        6:       t = $urandom;
        default: t = $urandom_range(16, 1);
      endcase
      case (ph)
        1:       lo = '0;
        2:       lo = '1;
        4:       lo = MV_W'($urandom);
        default: lo = MV_W'($urandom_range(4300, 3000));
      endcase
      load_config(t, lo, 13'd0);
      no_gaps = (ph == 0);
      for (int k = 0; k < 95; k++) begin
        r = $urandom_range(99);
        if (r < 42) send_event(FUNC_TICK, PIN_W'($urandom));
        else if (r < 54) send_event(FUNC_ACTIVITY, PIN_W'($urandom));
        else if (r < 74) send_event(FUNC_BATTERY, pick_pin());
        else if (r < 83) send_event(FUNC_SLEEP, PIN_W'($urandom));
        else if (r < 93) send_event(FUNC_WAKE, PIN_W'($urandom));
        else if (r < 96) send_event(FUNC_SPARE_6, PIN_W'($urandom));
        else send_event(FUNC_SPARE_7, PIN_W'($urandom));
      end
      no_gaps = 1'b0;
    end
  endtask

  // highest thresholds: any sample is critical; after a sample or a shutdown word, every word is ignored
  task automatic test_shutdown_lock();
    load_config(32'd2, 13'h1FFF, 13'h1FFF);
    send_event(FUNC_WAKE, '0);
    send_event(FUNC_TICK, '0);
    if ($urandom_range(1)) send_event(FUNC_BATTERY, '1);
    else send_event(FUNC_SHUTDOWN, PIN_W'($urandom));
    repeat (12) send_event(FUNC_W'($urandom_range(7)), PIN_W'($urandom));
    load_config(32'd1, 13'd0, 13'd0);
    send_event(FUNC_WAKE, '0);
    send_event(FUNC_ACTIVITY, '0);
    send_event(FUNC_BATTERY, 12'd2100);
    repeat (12) send_event(FUNC_W'($urandom_range(7)), PIN_W'($urandom));
  endtask

  always @(posedge clk) begin : result_check
    status_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 9);
      if (out_valid && !out_stall) begin
        n_results++;
        if (status_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX) $display("mismatch: status word with none pending");
        end else begin
          want = status_q.pop_front();
          if (want.mode !== mode || want.battery_mv !== battery_mv ||
              want.charge_percent !== charge_percent || want.battery_low !== battery_low ||
              want.battery_critical !== battery_critical ||
              want.sleep_request !== sleep_request || want.low_event !== low_event) begin
            n_bad++;
            if (n_bad <= REPORT_MAX) begin
              $display("mismatch at word %0d: exp mode %0d mv %0d pct %0d low %b crit %b req %b ev %b",
                       n_results, want.mode, want.battery_mv, want.charge_percent,
                       want.battery_low, want.battery_critical, want.sleep_request,
                       want.low_event);
              $display("                   got mode %0d mv %0d pct %0d low %b crit %b req %b ev %b",
                       mode, battery_mv, charge_percent, battery_low, battery_critical,
                       sleep_request, low_event);
            end
          end
        end
      end
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck = stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("no progress for %0d cycles, %0d words pending", stuck, status_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    func      <= '0;
    pin_mv    <= '0;
    out_stall <= 1'b0;
    no_gaps     = 1'b0;
    n_bad       = 0;
    n_words     = 0;
    n_results   = 0;
    n_sleep_req = 0;
    n_low_ev    = 0;
    n_settings  = 0;
    stuck       = 0;
    st_mode     = MODE_ACTIVE;
    st_count    = '0;
    st_mv       = '0;
    st_pct      = '0;
    st_low      = 1'b0;
    st_crit     = 1'b0;
    cfg_timeout = RST_IDLE_TIMEOUT;
    cfg_low     = RST_LOW_THRESH;
    cfg_crit    = RST_CRIT_THRESH;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_on_defaults();
    test_idle_timeout();
    test_timeout_extremes();
    test_random_traffic();
    test_shutdown_lock();

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d event words, %0d status words, %0d register settings",
             n_words, n_results, n_settings);
    $display("%0d sleep requests and %0d low events expected, %0d mismatches",
             n_sleep_req, n_low_ev, n_bad);
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_percent.sv
hw/rtl/bpm_state.sv
hw/rtl/battery_power_mode_manager.sv
hw/rtl/bpm_checker.sv
verif/tb_top.sv
